// ===== rtl/core/sap1_pkg.sv =====
// sap1_pkg: shared types, opcode codes, micro-addresses and the control store
// of the sap-1 stepper core. Depends on nothing.

package sap1_pkg;

    // machine opcodes (high nibble of an instruction word)
    localparam logic [3:0] OP_LDA = 4'b0000;
    localparam logic [3:0] OP_ADD = 4'b0001;
    localparam logic [3:0] OP_SUB = 4'b0010;
    localparam logic [3:0] OP_JMP = 4'b0101;
    localparam logic [3:0] OP_OUT = 4'b1110;
    localparam logic [3:0] OP_HLT = 4'b1111;

    // last program address; stepping past it halts the machine
    localparam logic [3:0] LAST_ADDR = 4'd15;

    // action codes of an input word
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef logic [3:0] t_upc;

    // micro-addresses; the response step sits at the top so that its
    // fall-through wraps back to idle
    localparam t_upc U_IDLE  = 4'd0;
    localparam t_upc U_ACT   = 4'd1;
    localparam t_upc U_HCHK  = 4'd2;
    localparam t_upc U_FETCH = 4'd3;
    localparam t_upc U_IR    = 4'd4;
    localparam t_upc U_OPND  = 4'd5;
    localparam t_upc U_LDA   = 4'd6;
    localparam t_upc U_ADD   = 4'd7;
    localparam t_upc U_SUB   = 4'd8;
    localparam t_upc U_JMP   = 4'd9;
    localparam t_upc U_OUT   = 4'd10;
    localparam t_upc U_HLT   = 4'd11;
    localparam t_upc U_NOP   = 4'd12;
    localparam t_upc U_WRITE = 4'd13;
    localparam t_upc U_SPARE = 4'd14;
    localparam t_upc U_RESP  = 4'd15;

    // branch conditions of a micro-instruction
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_IS_WRITE,
        C_HALTED,
        C_DISPATCH,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_ADD,
        ALU_SUB
    } t_alu;

    // control word driving the datapath
    typedef struct packed {
        logic  in_ready;
        logic  rd_arg;
        logic  ld_ir;
        logic  ld_a;
        logic  ld_b;
        t_alu  alu;
        logic  pc_inc;
        logic  pc_jmp;
        logic  set_halt;
        logic  shown;
        logic  ran;
        logic  mem_we;
        logic  out_load;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic       accept;
        logic       is_write;
        logic       halted;
        logic [3:0] opcode;
        logic       out_busy;
    } t_stat;

    // dispatch table: opcode to micro-routine entry
    function automatic t_upc op_entry(input logic [3:0] op);
        t_upc e;
        unique case (op)
            OP_LDA:  e = U_LDA;
            OP_ADD:  e = U_ADD;
            OP_SUB:  e = U_SUB;
            OP_JMP:  e = U_JMP;
            OP_OUT:  e = U_OUT;
            OP_HLT:  e = U_HLT;
            default: e = U_NOP;
        endcase
        return e;
    endfunction

    // control store
    function automatic t_uword ucode_rom(input t_upc upc);
        t_uword w;
        w        = '0;
        w.cond   = C_NONE;
        w.target = U_IDLE;
        w.ctrl.alu = ALU_PASS;
        unique case (upc)
            U_IDLE: begin
                w.ctrl.in_ready = 1'b1;
                w.cond          = C_NO_ACCEPT;
                w.target        = U_IDLE;
            end
            U_ACT: begin
                w.cond   = C_IS_WRITE;
                w.target = U_WRITE;
            end
            U_HCHK: begin
                w.cond   = C_HALTED;
                w.target = U_RESP;
            end
            U_FETCH: begin
                w.ctrl.rd_arg = 1'b0;
            end
            U_IR: begin
                w.ctrl.ld_ir = 1'b1;
            end
            U_OPND: begin
                w.ctrl.rd_arg = 1'b1;
                w.cond        = C_DISPATCH;
            end
            U_LDA: begin
                w.ctrl.ld_a   = 1'b1;
                w.ctrl.pc_inc = 1'b1;
                w.ctrl.ran    = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = U_RESP;
            end
            U_ADD: begin
                w.ctrl.ld_a   = 1'b1;
                w.ctrl.ld_b   = 1'b1;
                w.ctrl.alu    = ALU_ADD;
                w.ctrl.pc_inc = 1'b1;
                w.ctrl.ran    = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = U_RESP;
            end
            U_SUB: begin
                w.ctrl.ld_a   = 1'b1;
                w.ctrl.ld_b   = 1'b1;
                w.ctrl.alu    = ALU_SUB;
                w.ctrl.pc_inc = 1'b1;
                w.ctrl.ran    = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = U_RESP;
            end
            U_JMP: begin
                w.ctrl.pc_jmp = 1'b1;
                w.ctrl.ran    = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = U_RESP;
            end
            U_OUT: begin
                w.ctrl.shown  = 1'b1;
                w.ctrl.pc_inc = 1'b1;
                w.ctrl.ran    = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = U_RESP;
            end
            U_HLT: begin
                w.ctrl.set_halt = 1'b1;
                w.ctrl.pc_inc   = 1'b1;
                w.ctrl.ran      = 1'b1;
                w.cond          = C_ALWAYS;
                w.target        = U_RESP;
            end
            U_NOP: begin
                w.ctrl.pc_inc = 1'b1;
                w.ctrl.ran    = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = U_RESP;
            end
            U_WRITE: begin
                w.ctrl.mem_we = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = U_RESP;
            end
            U_SPARE: begin
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
            U_RESP: begin
                w.ctrl.out_load = 1'b1;
                w.cond          = C_OUT_BUSY;
                w.target        = U_RESP;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/sap1_useq.sv =====
// sap1_useq: micro-sequencer; micro-pc, control store lookup and branching.
// Depends on sap1_pkg.

module sap1_useq import sap1_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output t_upc  o_upc
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_uw;
    logic   w_take;

    // micro-pc register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // control store read and branch decision
    always_comb begin
        w_uw = ucode_rom(r_upc);
        unique case (w_uw.cond)
            C_NONE:      w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_ACCEPT: w_take = !i_stat.accept;
            C_IS_WRITE:  w_take = i_stat.is_write;
            C_HALTED:    w_take = i_stat.halted;
            C_DISPATCH:  w_take = 1'b1;
            C_OUT_BUSY:  w_take = i_stat.out_busy;
            default:     w_take = 1'b0;
        endcase
        if (w_take) begin
            n_upc = (w_uw.cond == C_DISPATCH) ? op_entry(i_stat.opcode) : w_uw.target;
        end else begin
            n_upc = r_upc + t_upc'(1);
        end
    end

    assign o_ctrl = w_uw.ctrl;
    assign o_upc  = r_upc;

endmodule

// ===== rtl/core/sap1_datapath.sv =====
// sap1_datapath: program memory, pc, a, b, ir, halt flag and result register.
// Depends on sap1_pkg; driven by the control word from sap1_useq.

module sap1_datapath import sap1_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl      i_ctrl,
    output t_stat      o_stat,
    input  logic       i_valid,
    input  logic       i_action,
    input  logic [3:0] i_address,
    input  logic [7:0] i_word,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [3:0] o_program_counter,
    output logic [7:0] o_accumulator,
    output logic [7:0] o_operand_register,
    output logic       o_out_valid,
    output logic [7:0] o_out_value,
    output logic       o_halted,
    output logic       o_executed
);

    logic [7:0]  r_mem [16];
    logic [15:0] r_vld;
    logic [7:0]  r_rd_q;
    logic [3:0]  w_rd_addr;

    logic       r_act;
    logic [3:0] r_addr;
    logic [7:0] r_word;
    logic [7:0] r_ir;

    logic [3:0] r_pc,   n_pc;
    logic [7:0] r_a,    n_a;
    logic [7:0] r_b,    n_b;
    logic       r_halt, n_halt;
    logic       r_shown;
    logic       r_ran;

    logic       r_o_valid;
    logic [3:0] r_o_pc;
    logic [7:0] r_o_a;
    logic [7:0] r_o_b;
    logic       r_o_shown;
    logic [7:0] r_o_value;
    logic       r_o_halt;
    logic       r_o_ran;

    logic w_accept;
    logic w_out_busy;

    assign w_accept   = i_valid && i_ctrl.in_ready;
    assign w_out_busy = r_o_valid && !i_ready;

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= i_action;
            r_addr <= i_address;
            r_word <= i_word;
        end
    end

    // program memory, registered read
    assign w_rd_addr = i_ctrl.rd_arg ? r_ir[3:0] : r_pc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mem_we) begin
            r_mem[r_addr] <= r_word;
        end
        r_rd_q <= r_vld[w_rd_addr] ? r_mem[w_rd_addr] : 8'd0;
    end

    // per-word written marks; unwritten words read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctrl.mem_we) begin
            r_vld[r_addr] <= 1'b1;
        end
    end

    // instruction register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_ir) begin
            r_ir <= r_rd_q;
        end
    end

    // next architectural state
    always_comb begin
        n_pc   = r_pc;
        n_a    = r_a;
        n_b    = r_b;
        n_halt = r_halt || i_ctrl.set_halt;
        if (i_ctrl.ld_b) begin
            n_b = r_rd_q;
        end
        if (i_ctrl.ld_a) begin
            unique case (i_ctrl.alu)
                ALU_PASS: n_a = r_rd_q;
                ALU_ADD:  n_a = r_a + r_rd_q;
                ALU_SUB:  n_a = r_a - r_rd_q;
                default:  n_a = r_a;
            endcase
        end
        if (i_ctrl.pc_jmp) begin
            n_pc = r_ir[3:0];
        end else if (i_ctrl.pc_inc) begin
            n_pc = r_pc + 4'd1;
            if (r_pc == LAST_ADDR) begin
                n_halt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_a    <= '0;
            r_b    <= '0;
            r_halt <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_a    <= n_a;
            r_b    <= n_b;
            r_halt <= n_halt;
        end
    end

    // per-word flags, cleared as a word comes in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= 1'b0;
            r_ran   <= 1'b0;
        end else if (w_accept) begin
            r_shown <= 1'b0;
            r_ran   <= 1'b0;
        end else begin
            r_shown <= r_shown || i_ctrl.shown;
            r_ran   <= r_ran || i_ctrl.ran;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctrl.out_load && !w_out_busy) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load && !w_out_busy) begin
            r_o_pc    <= r_pc;
            r_o_a     <= r_a;
            r_o_b     <= r_b;
            r_o_shown <= r_shown;
            r_o_value <= r_shown ? r_a : 8'd0;
            r_o_halt  <= r_halt;
            r_o_ran   <= r_ran;
        end
    end

    // status for the sequencer
    always_comb begin
        o_stat.accept   = w_accept;
        o_stat.is_write = (r_act == ACT_WRITE);
        o_stat.halted   = r_halt;
        o_stat.opcode   = r_ir[7:4];
        o_stat.out_busy = w_out_busy;
    end

    assign o_valid            = r_o_valid;
    assign o_program_counter  = r_o_pc;
    assign o_accumulator      = r_o_a;
    assign o_operand_register = r_o_b;
    assign o_out_valid        = r_o_shown;
    assign o_out_value        = r_o_value;
    assign o_halted           = r_o_halt;
    assign o_executed         = r_o_ran;

endmodule

// ===== rtl/core/sap1_instruction_stepper_core.sv =====
// sap1_instruction_stepper_core: top level of the sap-1 stepper.
// Depends on sap1_pkg, sap1_useq and sap1_datapath.

// A word is either a memory write (action 0) or one instruction step
// (action 1); each accepted word returns exactly one result word with the
// machine state after it. Words are handled one at a time by a microcoded
// sequencer over a 16x8 program memory with a registered read port, so the
// cost per word is set by the micro-routine length: a write or a step while
// halted runs idle, action, write or halt check and response; an executed
// instruction adds fetch and operand read, each through the memory port,
// plus ir load and execute. The result sits in an output register; the
// next word is taken while it waits, and the sequencer only stalls if a new
// result is ready before the previous one has been taken. Memory reads as
// zero until written; no clearing pass is needed after reset.

module sap1_instruction_stepper_core import sap1_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [3:0] i_address,
    input  logic [7:0] i_word,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_program_counter,
    output logic [7:0] o_accumulator,
    output logic [7:0] o_operand_register,
    output logic       o_out_valid,
    output logic [7:0] o_out_value,
    output logic       o_halted,
    output logic       o_executed
);

    t_ctrl w_ctrl;
    t_stat w_stat;
    t_upc  w_upc;

    // sequencer
    sap1_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_upc   (w_upc)
    );

    // datapath
    sap1_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (w_ctrl),
        .o_stat             (w_stat),
        .i_valid            (i_valid),
        .i_action           (i_action),
        .i_address          (i_address),
        .i_word             (i_word),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_program_counter  (o_program_counter),
        .o_accumulator      (o_accumulator),
        .o_operand_register (o_operand_register),
        .o_out_valid        (o_out_valid),
        .o_out_value        (o_out_value),
        .o_halted           (o_halted),
        .o_executed         (o_executed)
    );

    assign o_ready = w_ctrl.in_ready;

    // words are only taken in the idle micro-step
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> (w_upc == U_IDLE))
        else $error("word accepted outside idle step");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.halted |=> w_stat.halted)
        else $error("halt flag dropped without reset");

    // an out display comes only from an executed instruction
    a_out_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> o_executed)
        else $error("out shown without execution");

    // no display means a zero display value
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_value == 8'd0))
        else $error("display value not zero");

endmodule

// ===== tb/sv/sap1_instruction_stepper_core_test.sv =====
// sap1_instruction_stepper_core_test: self-checking bench for the sap-1 stepper core.
// Depends on sap1_pkg and sap1_instruction_stepper_core; predicts every result
// word from its own machine model and compares them field by field.

module sap1_instruction_stepper_core_test;
    import sap1_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 1200;
    localparam int IDLE_PCT     = 9;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 700;
    localparam int DRAIN_CYCLES = 24;

    // one input word
    typedef struct packed {
        logic       action;
        logic [3:0] address;
        logic [7:0] value;
    } t_in_word;

    // architectural state of the machine
    typedef struct packed {
        logic [15:0][7:0] mem;
        logic [3:0]       pc;
        logic [7:0]       reg_a;
        logic [7:0]       reg_b;
        logic             halt;
    } t_sap1_state;

    // one result word
    typedef struct packed {
        logic [3:0] pc;
        logic [7:0] acc;
        logic [7:0] opnd;
        logic       out_valid;
        logic [7:0] out_value;
        logic       halted;
        logic       executed;
    } t_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_action = 1'b0;
    logic [3:0] i_address = 4'd0;
    logic [7:0] i_word = 8'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [3:0] o_program_counter;
    logic [7:0] o_accumulator;
    logic [7:0] o_operand_register;
    logic       o_out_valid;
    logic [7:0] o_out_value;
    logic       o_halted;
    logic       o_executed;

    t_in_word    pending_words[$];
    t_result     expected_results[$];
    t_sap1_state plan_state;
    t_sap1_state machine;
    logic        word_taken = 1'b0;
    int          words_in = 0;
    int          writes_seen = 0;
    int          steps_seen = 0;
    int          executed_seen = 0;
    int          out_seen = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    sap1_instruction_stepper_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_address          (i_address),
        .i_word             (i_word),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_program_counter  (o_program_counter),
        .o_accumulator      (o_accumulator),
        .o_operand_register (o_operand_register),
        .o_out_valid        (o_out_valid),
        .o_out_value        (o_out_value),
        .o_halted           (o_halted),
        .o_executed         (o_executed)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // machine state after one input word
    function automatic t_sap1_state advance_machine(t_sap1_state m, t_in_word w);
        t_sap1_state n;
        logic [3:0]  op;
        logic [3:0]  arg;
        n   = m;
        op  = m.mem[m.pc][7:4];
        arg = m.mem[m.pc][3:0];
        if (w.action == ACT_WRITE) begin
            n.mem[w.address] = w.value;
        end else if (!m.halt) begin
            unique case (op)
                OP_LDA: begin
                    n.reg_a = m.mem[arg];
                end
                OP_ADD: begin
                    n.reg_b = m.mem[arg];
                    n.reg_a = m.reg_a + m.mem[arg];
                end
                OP_SUB: begin
                    n.reg_b = m.mem[arg];
                    n.reg_a = m.reg_a - m.mem[arg];
                end
                OP_HLT: begin
                    n.halt = 1'b1;
                end
                default: ;
            endcase
            // jump loads the counter, everything else advances and may run off the end
            if (op == OP_JMP) begin
                n.pc = arg;
            end else begin
                if (m.pc == LAST_ADDR) begin
                    n.halt = 1'b1;
                end
                n.pc = m.pc + 4'd1;
            end
        end
        return n;
    endfunction

    // result word seen for a word taken in state m, leaving state n
    function automatic t_result machine_outputs(t_sap1_state m, t_in_word w, t_sap1_state n);
        t_result r;
        logic    ran;
        ran         = (w.action == ACT_STEP) && !m.halt;
        r.pc        = n.pc;
        r.acc       = n.reg_a;
        r.opnd      = n.reg_b;
        r.executed  = ran;
        r.out_valid = ran && (m.mem[m.pc][7:4] == OP_OUT);
        r.out_value = r.out_valid ? n.reg_a : 8'd0;
        r.halted    = n.halt;
        return r;
    endfunction

    // the next step would stop the machine
    function automatic logic step_would_halt(t_sap1_state m);
        logic [3:0] op;
        op = m.mem[m.pc][7:4];
        return !m.halt && (op == OP_HLT || (m.pc == LAST_ADDR && op != OP_JMP));
    endfunction

    task automatic push_word(logic action, logic [3:0] address, logic [7:0] value);
        t_in_word w;
        w.action  = action;
        w.address = address;
        w.value   = value;
        pending_words.push_back(w);
        plan_state = advance_machine(plan_state, w);
    endtask

    task automatic push_step();
        push_word(ACT_STEP, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // input driver: presents words on the falling edge, holds them until taken
    always @(negedge i_clk) begin : driver
        t_in_word nxt;
        logic     quiet;
        quiet = (words_in >= QUIET_FROM) && (words_in < QUIET_TO);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            if (!i_valid || word_taken) begin
                if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = pending_words.pop_front();
                    i_valid   <= 1'b1;
                    i_action  <= nxt.action;
                    i_address <= nxt.address;
                    i_word    <= nxt.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predicts on each taken word, checks each result word
    always @(posedge i_clk) begin : monitor
        t_in_word    taken;
        t_sap1_state nxt_state;
        t_result     exp_r;
        word_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                taken.action  = i_action;
                taken.address = i_address;
                taken.value   = i_word;
                nxt_state = advance_machine(machine, taken);
                expected_results.push_back(machine_outputs(machine, taken, nxt_state));
                machine = nxt_state;
                words_in++;
                if (taken.action == ACT_WRITE) begin
                    writes_seen++;
                end else begin
                    steps_seen++;
                end
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no word pending");
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("program_counter", exp_r.pc, o_program_counter);
                    check_field("accumulator", exp_r.acc, o_accumulator);
                    check_field("operand_register", exp_r.opnd, o_operand_register);
                    check_field("out_valid", exp_r.out_valid, o_out_valid);
                    check_field("out_value", exp_r.out_value, o_out_value);
                    check_field("halted", exp_r.halted, o_halted);
                    check_field("executed", exp_r.executed, o_executed);
                    if (o_executed) begin
                        executed_seen++;
                    end
                    if (o_out_valid) begin
                        out_seen++;
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int         n_random;
        int         burst;
        int         mode;
        logic [7:0] fix;
        plan_state = '0;
        machine    = '0;

        // directed program: wraps of add and sub, out, unknown opcode, jumps, jump at 15
        push_word(ACT_WRITE, 4'd0,  {OP_LDA, 4'd13});
        push_word(ACT_WRITE, 4'd1,  {OP_ADD, 4'd14});
        push_word(ACT_WRITE, 4'd2,  {OP_SUB, 4'd12});
        push_word(ACT_WRITE, 4'd3,  {OP_OUT, 4'd0});
        push_word(ACT_WRITE, 4'd4,  8'h7f);
        push_word(ACT_WRITE, 4'd5,  {OP_JMP, 4'd7});
        push_word(ACT_WRITE, 4'd7,  {OP_ADD, 4'd15});
        push_word(ACT_WRITE, 4'd8,  {OP_JMP, 4'd15});
        push_word(ACT_WRITE, 4'd12, 8'h01);
        push_word(ACT_WRITE, 4'd13, 8'hff);
        push_word(ACT_WRITE, 4'd14, 8'h01);
        push_word(ACT_WRITE, 4'd15, {OP_JMP, 4'd0});
        repeat (9) push_step();
        // rewrite the running program, then execute the new word
        push_word(ACT_WRITE, 4'd0, 8'h00);
        push_step();

        // random programs loaded and run in bursts; steps that would stop
        // the machine get their word replaced first
        n_random = 0;
        while (n_random < RANDOM_WORDS) begin
            burst = $urandom_range(0, 4);
            repeat (burst) begin
                push_word(ACT_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                n_random++;
            end
            burst = $urandom_range(1, 10);
            repeat (burst) begin
                if (step_would_halt(plan_state)) begin
                    if (plan_state.pc == LAST_ADDR) begin
                        fix = {OP_JMP, 4'($urandom_range(0, 15))};
                    end else begin
                        do fix = 8'($urandom_range(0, 255)); while (fix[7:4] == OP_HLT);
                    end
                    push_word(ACT_WRITE, plan_state.pc, fix);
                end
                push_step();
                n_random++;
            end
        end

        // stop the machine once: halt mid-memory, halt at 15, or run off the end
        mode = $urandom_range(0, 2);
        if (mode == 0) begin
            push_word(ACT_WRITE, plan_state.pc, {OP_HLT, 4'($urandom_range(0, 15))});
            push_step();
        end else begin
            push_word(ACT_WRITE, plan_state.pc, {OP_JMP, 4'd14});
            push_step();
            push_word(ACT_WRITE, 4'd14, {OP_OUT, 4'($urandom_range(0, 15))});
            push_word(ACT_WRITE, 4'd15,
                      {(mode == 1) ? OP_HLT : OP_ADD, 4'($urandom_range(0, 15))});
            push_step();
            push_step();
        end
        // halted machine: steps do nothing, writes still land
        repeat (5) begin
            push_step();
            push_word(ACT_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d result words never arrived", expected_results.size());
            mismatches++;
        end

        $display("covered %0d writes and %0d steps: %0d instructions executed, %0d OUT results",
                 writes_seen, steps_seen, executed_seen, out_seen);
        $display("halt path %0d, machine halted at end %0d, mismatches %0d",
                 mode, machine.halt, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
